/* hdl/tkd_pkg.sv */
// Shared types and constants for the terminal key decoder with cursor tracking.
`timescale 1ns / 1ps

package tkd_pkg;

    // Byte codes that drive the escape sequence parser.
    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_BRACKET = 8'h5B;
    localparam logic [7:0] BYTE_LETTER_O = 8'h4F;
    localparam logic [7:0] BYTE_TILDE   = 8'h7E;

    // Opcodes of an input transaction.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_ROWS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_COLS = 1'b1;

    // Reset values of the screen size registers.
    localparam logic [15:0] ROWS_RESET = 16'd24;
    localparam logic [15:0] COLS_RESET = 16'd80;

    // Queue between the parser and the cursor stage.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Decoded key kinds.
    typedef enum logic [3:0] {
        KEY_PLAIN = 4'd0,
        KEY_UP    = 4'd1,
        KEY_DOWN  = 4'd2,
        KEY_RIGHT = 4'd3,
        KEY_LEFT  = 4'd4,
        KEY_HOME  = 4'd5,
        KEY_END   = 4'd6,
        KEY_DEL   = 4'd7,
        KEY_PGUP  = 4'd8,
        KEY_PGDN  = 4'd9
    } t_key_kind;

    // Input transaction payload.
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [3:0]  key_kind;
        logic [7:0]  plain_value;
        logic [15:0] cursor_col;
        logic [15:0] cursor_row;
    } t_out_item;

    // One decoded key on its way from the parser to the cursor stage.
    typedef struct packed {
        t_key_kind  kind;
        logic [7:0] value;
    } t_key_event;

    // Handshake between the parser and the queue.
    typedef struct packed {
        logic       push;
        t_key_event event_data;
    } t_push_req;

    // Handshake between the queue and the cursor stage.
    typedef struct packed {
        logic       not_empty;
        t_key_event event_data;
    } t_pop_view;

endpackage

/* hdl/tkd_front.sv */
// Escape sequence parser: accepts input transactions and classifies them into keys.
`timescale 1ns / 1ps

module tkd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tkd_pkg::t_in_item i_in_data,
    input  logic              i_queue_full,
    output tkd_pkg::t_push_req o_push
);
    import tkd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_FIRST = 2'd2,
        PH_DIGIT = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_digit, n_digit;
    logic       w_accept;
    logic       w_emit;
    t_key_kind  w_kind;
    logic [7:0] w_byte;

    // Key for the final letter of ESC [ letter.
    function automatic t_key_kind letter_key(input logic [7:0] b);
        t_key_kind k;
        unique case (b)
            8'h41:   k = KEY_UP;
            8'h42:   k = KEY_DOWN;
            8'h43:   k = KEY_RIGHT;
            8'h44:   k = KEY_LEFT;
            8'h48:   k = KEY_HOME;
            8'h46:   k = KEY_END;
            default: k = KEY_PLAIN;
        endcase
        return k;
    endfunction

    // Key for the digit of ESC [ digit ~.
    function automatic t_key_kind digit_key(input logic [7:0] d);
        t_key_kind k;
        unique case (d)
            8'h31:   k = KEY_HOME;
            8'h33:   k = KEY_DEL;
            8'h34:   k = KEY_END;
            8'h35:   k = KEY_PGUP;
            8'h36:   k = KEY_PGDN;
            8'h37:   k = KEY_HOME;
            8'h38:   k = KEY_END;
            default: k = KEY_PLAIN;
        endcase
        return k;
    endfunction

    // The parser takes a transaction whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;
    assign w_byte     = i_in_data.rx_byte;

    // Next parse state and the key that this transaction completes, if any.
    always_comb begin
        n_phase = r_phase;
        n_first = r_first;
        n_digit = r_digit;
        w_emit  = 1'b0;
        w_kind  = KEY_PLAIN;
        o_push.event_data.value = BYTE_ESC;
        if (i_in_data.opcode == OP_TIMEOUT) begin
            // A timeout aborts an open sequence as a plain ESC.
            w_emit  = (r_phase != PH_IDLE);
            n_phase = PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_byte == BYTE_ESC) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_emit = 1'b1;
                        o_push.event_data.value = w_byte;
                    end
                end
                PH_ESC: begin
                    n_first = w_byte;
                    n_phase = PH_FIRST;
                end
                PH_FIRST: begin
                    n_phase = PH_IDLE;
                    w_emit  = 1'b1;
                    if (r_first == BYTE_BRACKET) begin
                        if (w_byte >= 8'h30 && w_byte <= 8'h39) begin
                            n_digit = w_byte;
                            n_phase = PH_DIGIT;
                            w_emit  = 1'b0;
                        end else begin
                            w_kind = letter_key(w_byte);
                        end
                    end else if (r_first == BYTE_LETTER_O) begin
                        if (w_byte == 8'h48) begin
                            w_kind = KEY_HOME;
                        end else if (w_byte == 8'h46) begin
                            w_kind = KEY_END;
                        end
                    end
                end
                PH_DIGIT: begin
                    n_phase = PH_IDLE;
                    w_emit  = 1'b1;
                    if (w_byte == BYTE_TILDE) begin
                        w_kind = digit_key(r_digit);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        // The byte value is reported only for plain keys.
        if (w_kind != KEY_PLAIN) begin
            o_push.event_data.value = 8'h00;
        end
        o_push.event_data.kind = w_kind;
        o_push.push = w_accept && w_emit;
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
            r_digit <= 8'h00;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_digit <= n_digit;
        end
    end

endmodule

/* hdl/tkd_queue.sv */
// Short key queue that decouples the parser from the cursor stage.
`timescale 1ns / 1ps

module tkd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkd_pkg::t_push_req i_push,
    output logic               o_full,
    input  logic               i_pop,
    output tkd_pkg::t_pop_view o_view
);
    import tkd_pkg::*;

    t_key_event             r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   w_pop;

    assign o_full             = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_view.not_empty   = (r_count != '0);
    assign o_view.event_data  = r_mem[r_rd_ptr];
    assign w_pop              = i_pop && o_view.not_empty;

    // Entry storage; the parser never pushes while the queue is full.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.event_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/tkd_back.sv */
// Cursor stage: applies keys to the stored cursor and registers the output transaction.
`timescale 1ns / 1ps

module tkd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tkd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    input  tkd_pkg::t_pop_view           i_view,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tkd_pkg::t_out_item           o_out_data
);
    import tkd_pkg::*;

    logic [15:0] r_rows;
    logic [15:0] r_cols;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        w_slot_free;
    t_key_kind   w_kind;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_pop       = i_view.not_empty && w_slot_free;
    assign w_kind      = i_view.event_data.kind;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Cursor move with clamping at zero and at the screen limits.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (w_kind)
            KEY_UP: begin
                if (r_row != 16'd0) begin
                    n_row = r_row - 16'd1;
                end
            end
            KEY_DOWN: begin
                if (({1'b0, r_row} + 17'd1) < {1'b0, r_rows}) begin
                    n_row = r_row + 16'd1;
                end
            end
            KEY_LEFT: begin
                if (r_col != 16'd0) begin
                    n_col = r_col - 16'd1;
                end
            end
            KEY_RIGHT: begin
                if (({1'b0, r_col} + 17'd1) < {1'b0, r_cols}) begin
                    n_col = r_col + 16'd1;
                end
            end
            default: begin
                n_col = r_col;
                n_row = r_row;
            end
        endcase
    end

    // Screen size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_ROWS: r_rows <= i_cfg_data;
                CFG_SCREEN_COLS: r_cols <= i_cfg_data;
                default:         r_rows <= r_rows;
            endcase
        end
    end

    // Cursor and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 16'd0;
            r_row       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.key_kind    <= w_kind;
            r_out.plain_value <= i_view.event_data.value;
            r_out.cursor_col  <= n_col;
            r_out.cursor_row  <= n_row;
        end
    end

endmodule

/* hdl/terminal_key_decoder_cursor.sv */
// Top level of the terminal key decoder with cursor tracking.
//
//  Port group  Direction  Handshake                 Payload
//  input       in         i_in_valid / o_in_stall   i_in_data  (opcode, rx_byte)
//  output      out        o_out_valid / i_out_stall o_out_data (key, value, col, row)
//  config      in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One input transaction is taken every cycle while the four-entry key queue has room.
// A key passes from the queue memory into the output register of the cursor stage; the cursor
// stage applies one key per cycle, so with no output stall the rate is one per cycle.
// Reset is synchronous and active low; it clears the parser, the queue and the cursor
// and loads 24 rows by 80 columns. An output stall backs up the queue, and the input
// stalls only once the queue is full.
`timescale 1ns / 1ps

module terminal_key_decoder_cursor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tkd_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tkd_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tkd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import tkd_pkg::*;

    t_push_req w_push;
    t_pop_view w_view;
    logic      w_full;
    logic      w_pop;

    // Parser side.
    tkd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (w_full),
        .o_push       (w_push)
    );

    // Key queue.
    tkd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_view  (w_view)
    );

    // Cursor side.
    tkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_view      (w_view),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/tkd_checker.sv */
// Port-level checker for the terminal key decoder and its bind to the top level.
`timescale 1ns / 1ps

module tkd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tkd_pkg::t_out_item o_out_data
);
    import tkd_pkg::*;

    // Reset leaves no output transaction pending.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled output transaction holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

    // Only plain keys carry a byte value.
    a_value_plain_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.key_kind != KEY_PLAIN)) |->
            (o_out_data.plain_value == 8'h00))
        else $error("non-plain key with byte value");

    // Key kinds stay within the decoded set.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.key_kind <= KEY_PGDN))
        else $error("key kind out of range");

endmodule

bind terminal_key_decoder_cursor tkd_checker u_tkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
